// ----- design/bba_pkg.sv -----
// Package with the shared types and constants of the buddy block allocator.
package bba_pkg;

  localparam int LOG2_UNITS = 6;
  localparam int NUM_UNITS  = 64;

  typedef logic [LOG2_UNITS-1:0] unit_t;
  typedef logic [2:0]            order_t;

  // One slot entry: head flag, busy flag and order.
  typedef struct packed {
    logic   head;
    logic   busy;
    order_t order;
  } slot_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_IGNORE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_SPLIT,
    S_FREE_RD,
    S_FREE_CHK,
    S_BUD_CHK,
    S_OUT
  } fsm_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

// ----- design/buddy_block_allocator_core.sv -----
// Buddy block allocator: top level with slot memory and sequencer.
//
// Usage: requests arrive on the s_axis channel (tdata: opcode, request_bytes,
// free_unit from the lowest bit up). Each request produces exactly one
// response on the m_axis channel (tdata: status, block_unit, block_order).
// The unit size is written on the cfg channel (log2 of bytes per unit) while
// the block is idle.
// One request is handled at a time. An allocate reads all 64 slot entries
// through the single-port slot memory, one a cycle, then writes the free
// upper half of each split and marks the chosen block busy, or reports out
// of memory if no free block fits. A free reads and checks the slot (one that
// is not a busy head is ignored), then reads and checks each buddy in turn,
// merging while it is a free head of the same order, up to the top order.
// The response register then holds the result until the sink takes it, and
// no new request is taken while it waits; the next request can be taken in
// the cycle after the response transfer.
// After reset the block clears all 64 slot entries and accepts no request
// while it does so; then the whole region is one free block.
// If the sink stalls, the response is held stable on m_axis.
module buddy_block_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // opcode, request_bytes[26:0], free_unit[5:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status[1:0], block_unit[5:0], block_order[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int CW = bba_pkg::LOG2_UNITS + 1;

  bba_pkg::fsm_t state, state_next;
  logic [4:0] min_order;

  // Slot memory, one read or write port.
  bba_pkg::slot_t mem [bba_pkg::NUM_UNITS];
  bba_pkg::slot_t rd_data;
  logic           mem_we;
  bba_pkg::unit_t mem_addr;
  bba_pkg::slot_t mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  // Request registers.
  logic [5:0]     k;
  bba_pkg::unit_t fu;
  logic [CW-1:0]  cnt, cnt_next;
  logic           found, found_next;
  bba_pkg::unit_t best, best_next;
  bba_pkg::order_t ord, ord_next;
  bba_pkg::unit_t pos, pos_next;
  bba_pkg::unit_t bud;
  logic [1:0]     r_st, r_st_next;
  bba_pkg::unit_t r_unit, r_unit_next;
  bba_pkg::order_t r_ord, r_ord_next;
  logic [5:0]     k_in;

  // Rounded exponent: smallest k with 2^k at least the request.
  always_comb begin
    logic [26:0] v;
    v = s_axis_tdata[27:1] - 27'd1;
    k_in = '0;
    if (s_axis_tdata[27:1] > 27'd1) begin
      for (int i = 0; i < 27; i++) begin
        if (v[i]) k_in = 6'(i + 1);
      end
    end
  end

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == bba_pkg::S_IDLE);
  assign m_axis_tvalid = (state == bba_pkg::S_OUT);
  assign m_axis_tdata  = {5'd0, r_ord, r_unit, r_st};
  assign bud = pos ^ bba_pkg::unit_t'(1 << ord);

  // Fit test of a slot order against the request exponent.
  function automatic logic fits(bba_pkg::order_t o, logic [4:0] m, logic [5:0] kk);
    fits = ({3'd0, o} + {2'd0, m}) >= kk;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bba_pkg::S_CLEAR;
      min_order <= 5'd4;
      cnt       <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_valid) min_order <= cfg_data;
    end
    found  <= found_next;
    best   <= best_next;
    ord    <= ord_next;
    pos    <= pos_next;
    r_st   <= r_st_next;
    r_unit <= r_unit_next;
    r_ord  <= r_ord_next;
    if (s_axis_tvalid && s_axis_tready) begin
      k  <= k_in;
      fu <= s_axis_tdata[33:28];
    end
  end

  // Sequencer.
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    found_next  = found;
    best_next   = best;
    ord_next    = ord;
    pos_next    = pos;
    r_st_next   = r_st;
    r_unit_next = r_unit;
    r_ord_next  = r_ord;
    mem_we      = 1'b0;
    mem_addr    = cnt[CW-2:0];
    mem_wdata   = '0;
    unique case (state)
      bba_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        if (cnt == '0) mem_wdata = '{head: 1'b1, busy: 1'b0,
                                     order: bba_pkg::order_t'(bba_pkg::LOG2_UNITS)};
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(bba_pkg::NUM_UNITS - 1)) begin
          state_next = bba_pkg::S_IDLE;
          cnt_next   = '0;
        end
      end
      bba_pkg::S_IDLE: begin
        cnt_next   = '0;
        found_next = 1'b0;
        if (s_axis_tvalid) begin
          if (s_axis_tdata[0] == bba_pkg::OP_ALLOC) begin
            mem_addr   = '0;
            cnt_next   = CW'(1);
            state_next = bba_pkg::S_SCAN;
          end else begin
            state_next = bba_pkg::S_FREE_RD;
          end
        end
      end
      bba_pkg::S_SCAN, bba_pkg::S_SCAN_LAST: begin
        // rd_data is the entry at cnt-1.
        if (rd_data.head && !rd_data.busy && fits(rd_data.order, min_order, k) &&
            (!found || rd_data.order < ord)) begin
          found_next = 1'b1;
          best_next  = bba_pkg::unit_t'(cnt - 1'b1);
          ord_next   = rd_data.order;
        end
        if (state == bba_pkg::S_SCAN) begin
          cnt_next = cnt + 1'b1;
          if (cnt == CW'(bba_pkg::NUM_UNITS - 1)) state_next = bba_pkg::S_SCAN_LAST;
        end else begin
          state_next = bba_pkg::S_SPLIT;
        end
      end
      bba_pkg::S_SPLIT: begin
        if (!found) begin
          r_st_next   = bba_pkg::ST_OOM;
          r_unit_next = '0;
          r_ord_next  = '0;
          state_next  = bba_pkg::S_OUT;
        end else if (ord >= 3'd1 && fits(ord - 3'd1, min_order, k)) begin
          // Upper half becomes a free head.
          mem_we     = 1'b1;
          mem_addr   = best + bba_pkg::unit_t'(1 << (ord - 3'd1));
          mem_wdata  = '{head: 1'b1, busy: 1'b0, order: ord - 3'd1};
          ord_next   = ord - 3'd1;
        end else begin
          mem_we      = 1'b1;
          mem_addr    = best;
          mem_wdata   = '{head: 1'b1, busy: 1'b1, order: ord};
          r_st_next   = bba_pkg::ST_OK;
          r_unit_next = best;
          r_ord_next  = ord;
          state_next  = bba_pkg::S_OUT;
        end
      end
      bba_pkg::S_FREE_RD: begin
        mem_addr   = fu;
        state_next = bba_pkg::S_FREE_CHK;
      end
      bba_pkg::S_FREE_CHK: begin
        if (!rd_data.head || !rd_data.busy) begin
          r_st_next   = bba_pkg::ST_IGNORE;
          r_unit_next = fu;
          r_ord_next  = '0;
          state_next  = bba_pkg::S_OUT;
        end else begin
          mem_we    = 1'b1;
          mem_addr  = fu;
          mem_wdata = '{head: 1'b1, busy: 1'b0, order: rd_data.order};
          pos_next  = fu;
          ord_next  = rd_data.order;
          if (rd_data.order >= 3'(bba_pkg::LOG2_UNITS)) begin
            r_st_next   = bba_pkg::ST_OK;
            r_unit_next = fu;
            r_ord_next  = rd_data.order;
            state_next  = bba_pkg::S_OUT;
          end else begin
            // Read the buddy next.
            state_next = bba_pkg::S_BUD_CHK;
          end
        end
      end
      bba_pkg::S_BUD_CHK: begin
        // Issue the buddy read while cnt[0]==0, then check it while cnt[0]==1.
        if (cnt[0] == 1'b0) begin
          mem_addr = bud;
          cnt_next = CW'(1);
        end else begin
          cnt_next = '0;
          if (rd_data.head && !rd_data.busy && rd_data.order == ord) begin
            // Clear the higher head, grow the lower one.
            mem_we      = 1'b1;
            mem_addr    = (pos < bud) ? bud : pos;
            mem_wdata   = '0;
            pos_next    = (pos < bud) ? pos : bud;
            ord_next    = ord + 3'd1;
            r_unit_next = (pos < bud) ? pos : bud;
            r_ord_next  = ord + 3'd1;
          end else begin
            r_st_next   = bba_pkg::ST_OK;
            r_unit_next = pos;
            r_ord_next  = ord;
            state_next  = bba_pkg::S_OUT;
            // Write the merged head's order.
            mem_we    = 1'b1;
            mem_addr  = pos;
            mem_wdata = '{head: 1'b1, busy: 1'b0, order: ord};
          end
        end
      end
      bba_pkg::S_OUT: begin
        if (m_axis_tready) state_next = bba_pkg::S_IDLE;
      end
      default: state_next = bba_pkg::S_IDLE;
    endcase
    // At top order, finish after clearing the high head: write lower head.
    if (state == bba_pkg::S_BUD_CHK && cnt[0] == 1'b0 && ord >= 3'(bba_pkg::LOG2_UNITS)) begin
      mem_we      = 1'b1;
      mem_addr    = pos;
      mem_wdata   = '{head: 1'b1, busy: 1'b0, order: ord};
      r_st_next   = bba_pkg::ST_OK;
      r_unit_next = pos;
      r_ord_next  = ord;
      cnt_next    = '0;
      state_next  = bba_pkg::S_OUT;
    end
  end

endmodule
